[src/bmrtc_pkg.sv]
// shared types and constants for the bank mapper with clock
package bmrtc_pkg;

   localparam int ROM_BANK_BITS_DEFAULT = 7;
   localparam int RAM_BANKS_DEFAULT     = 4;

   // item function codes
   localparam logic [1:0] FUNC_READ  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   typedef enum logic [2:0] {
      TGT_NONE = 3'd0,
      TGT_ROM  = 3'd1,
      TGT_RAM  = 3'd2,
      TGT_CLK  = 3'd3,
      TGT_CTRL = 3'd4
   } target_type;

   // clock register indexes within the clock bank range
   localparam logic [2:0] CLK_SEC   = 3'd0;
   localparam logic [2:0] CLK_MIN   = 3'd1;
   localparam logic [2:0] CLK_HOUR  = 3'd2;
   localparam logic [2:0] CLK_DAY   = 3'd3;
   localparam logic [2:0] CLK_FLAGS = 3'd4;

   // normalization field selects
   localparam logic [1:0] FLD_SEC  = 2'd0;
   localparam logic [1:0] FLD_MIN  = 2'd1;
   localparam logic [1:0] FLD_HOUR = 2'd2;

   // bits of the flags register
   localparam int FLAG_DAYHIGH  = 0;
   localparam int FLAG_HALT     = 6;
   localparam int FLAG_OVERFLOW = 7;

   localparam logic [7:0] SEC_LIMIT  = 8'd60;
   localparam logic [7:0] MIN_LIMIT  = 8'd60;
   localparam logic [7:0] HOUR_LIMIT = 8'd24;

   localparam logic [7:0] CLK_BANK_FIRST = 8'h08;
   localparam logic [7:0] CLK_BANK_LAST  = 8'h0C;

endpackage

[src/bank_mapper_with_rtc.sv]
// cartridge bank controller with a real-time clock, top level
//
// One item is taken while busy is low and start is high. A bus read or write
// is decoded in the EXEC state, which registers its result; rsp_valid marks
// the result for one cycle and the receiver cannot hold it off. A one-second
// tick passes through the EXEC and TICK states; when the clock is frozen or
// halted TICK gives the result, else TICK adds a second and NORM takes one
// step of the shared compare/subtract unit at a time: one step for each field
// that is found in range on the way back up and one for each carry of 60
// seconds, 60 minutes or 24 hours. Values written out of range by software
// need, for each extra carry, the carry step and the field checks that follow
// it. A tick gives a result with all fields zero. busy may fall in the same
// cycle that the result is shown, so the next item can be taken then.
module bank_mapper_with_rtc
   import bmrtc_pkg::*;
#(
   parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEFAULT,
   parameter int RAM_BANKS     = RAM_BANKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   output logic [2:0]  rsp_target,
   output logic [20:0] rsp_mapped_addr,
   output logic [7:0]  rsp_clock_read_data,
   output logic        rsp_is_write
);

   localparam logic [7:0] RomMask   = 8'((1 << ROM_BANK_BITS) - 1);
   localparam logic [7:0] RamBankNr = 8'(RAM_BANKS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK,
      ST_NORM
   } state_type;

   state_type   state_ff;
   logic [1:0]  func_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   logic [7:0]  ram_enable_ff;
   logic [7:0]  rom_bank_ff;
   logic [7:0]  ram_bank_ff;
   logic [7:0]  latch_ff;
   logic        frozen_ff;
   logic [7:0]  sec_ff;
   logic [7:0]  min_ff;
   logic [7:0]  hour_ff;
   logic [7:0]  day_ff;
   logic [7:0]  flags_ff;
   logic [1:0]  fld_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_target_ff;
   logic [20:0] rsp_maddr_ff;
   logic [7:0]  rsp_rdata_ff;
   logic        rsp_wr_ff;

   // decode of the held bus access
   target_type  dec_target;
   logic [20:0] dec_maddr;
   logic [7:0]  dec_rdata;
   logic        dec_wr;
   logic        wr_ram_enable;
   logic        wr_rom_bank;
   logic        wr_ram_bank;
   logic        wr_latch;
   logic        wr_clk;
   logic        clk_bank_ok;
   logic [7:0]  rom_bank_sel;
   logic [21:0] rom_full;
   logic [7:0]  clk_rd_sel;

   // shared compare/subtract unit and carry incrementer
   logic [7:0]  norm_opnd;
   logic [7:0]  norm_limit;
   logic        norm_ge;
   logic [7:0]  norm_diff;
   logic [7:0]  norm_upper;
   logic [7:0]  norm_upper_inc;

   assign clk_bank_ok = (ram_bank_ff >= CLK_BANK_FIRST) && (ram_bank_ff <= CLK_BANK_LAST);
   assign rom_bank_sel = ((rom_bank_ff & RomMask) == 8'd0) ? 8'd1 : (rom_bank_ff & RomMask);
   assign rom_full = {rom_bank_sel, addr_ff[13:0]};

   always_comb begin
      unique case (ram_bank_ff[2:0])
         CLK_SEC:   clk_rd_sel = sec_ff;
         CLK_MIN:   clk_rd_sel = min_ff;
         CLK_HOUR:  clk_rd_sel = hour_ff;
         CLK_DAY:   clk_rd_sel = day_ff;
         CLK_FLAGS: clk_rd_sel = flags_ff;
         default:   clk_rd_sel = 8'd0;
      endcase
   end

   always_comb begin
      dec_target    = TGT_NONE;
      dec_maddr     = 21'd0;
      dec_rdata     = 8'd0;
      dec_wr        = 1'b0;
      wr_ram_enable = 1'b0;
      wr_rom_bank   = 1'b0;
      wr_ram_bank   = 1'b0;
      wr_latch      = 1'b0;
      wr_clk        = 1'b0;
      if (func_ff == FUNC_READ || func_ff == FUNC_WRITE) begin
         if (addr_ff[15:13] == 3'b101) begin
            if (ram_enable_ff != 8'd0) begin
               if (ram_bank_ff < RamBankNr) begin
                  dec_target = TGT_RAM;
                  dec_maddr  = {6'd0, ram_bank_ff[1:0], addr_ff[12:0]};
                  dec_wr     = (func_ff == FUNC_WRITE);
               end else if (clk_bank_ok) begin
                  dec_target = TGT_CLK;
                  if (func_ff == FUNC_WRITE) begin
                     wr_clk = 1'b1;
                     dec_wr = 1'b1;
                  end else begin
                     dec_rdata = clk_rd_sel;
                  end
               end
            end
         end else if (func_ff == FUNC_READ) begin
            if (addr_ff[15:14] == 2'b00) begin
               dec_target = TGT_ROM;
               dec_maddr  = {5'd0, addr_ff};
            end else if (addr_ff[15:14] == 2'b01) begin
               dec_target = TGT_ROM;
               dec_maddr  = rom_full[20:0];
            end
         end else if (!addr_ff[15]) begin
            dec_target = TGT_CTRL;
            dec_wr     = 1'b1;
            case (addr_ff[14:13])
               2'b00:   wr_ram_enable = 1'b1;
               2'b01:   wr_rom_bank   = 1'b1;
               2'b10:   wr_ram_bank   = 1'b1;
               default: wr_latch      = 1'b1;
            endcase
         end
      end
   end

   always_comb begin
      unique case (fld_ff)
         FLD_SEC: begin
            norm_opnd  = sec_ff;
            norm_limit = SEC_LIMIT;
            norm_upper = min_ff;
         end
         FLD_MIN: begin
            norm_opnd  = min_ff;
            norm_limit = MIN_LIMIT;
            norm_upper = hour_ff;
         end
         FLD_HOUR: begin
            norm_opnd  = hour_ff;
            norm_limit = HOUR_LIMIT;
            norm_upper = day_ff;
         end
         default: begin
            norm_opnd  = 8'd0;
            norm_limit = 8'd0;
            norm_upper = 8'd0;
         end
      endcase
   end

   assign norm_ge        = (norm_opnd >= norm_limit);
   assign norm_diff      = norm_opnd - norm_limit;
   assign norm_upper_inc = norm_upper + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ram_enable_ff <= 8'd0;
         rom_bank_ff   <= 8'd0;
         ram_bank_ff   <= 8'd0;
         latch_ff      <= 8'd0;
         frozen_ff     <= 1'b0;
         sec_ff        <= 8'd0;
         min_ff        <= 8'd0;
         hour_ff       <= 8'd0;
         day_ff        <= 8'd0;
         flags_ff      <= 8'd0;
         fld_ff        <= FLD_SEC;
         rsp_valid_ff  <= 1'b0;
         rsp_target_ff <= TGT_NONE;
         rsp_maddr_ff  <= 21'd0;
         rsp_rdata_ff  <= 8'd0;
         rsp_wr_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  addr_ff  <= req_addr;
                  data_ff  <= req_write_data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (func_ff == FUNC_TICK) begin
                  state_ff <= ST_TICK;
               end else begin
                  if (wr_ram_enable) ram_enable_ff <= data_ff;
                  if (wr_rom_bank)   rom_bank_ff   <= data_ff;
                  if (wr_ram_bank)   ram_bank_ff   <= data_ff;
                  if (wr_latch) begin
                     // a 0-to-1 latch sequence flips the freeze
                     if (latch_ff == 8'd0 && data_ff == 8'd1) frozen_ff <= !frozen_ff;
                     latch_ff <= data_ff;
                  end
                  if (wr_clk) begin
                     unique case (ram_bank_ff[2:0])
                        CLK_SEC:   sec_ff   <= data_ff;
                        CLK_MIN:   min_ff   <= data_ff;
                        CLK_HOUR:  hour_ff  <= data_ff;
                        CLK_DAY:   day_ff   <= data_ff;
                        CLK_FLAGS: flags_ff <= data_ff;
                        default:   ;
                     endcase
                  end
                  rsp_valid_ff  <= 1'b1;
                  rsp_target_ff <= dec_target;
                  rsp_maddr_ff  <= dec_maddr;
                  rsp_rdata_ff  <= dec_rdata;
                  rsp_wr_ff     <= dec_wr;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_TICK: begin
               if (frozen_ff || flags_ff[FLAG_HALT]) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_target_ff <= TGT_NONE;
                  rsp_maddr_ff  <= 21'd0;
                  rsp_rdata_ff  <= 8'd0;
                  rsp_wr_ff     <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else begin
                  sec_ff   <= sec_ff + 8'd1;
                  fld_ff   <= FLD_SEC;
                  state_ff <= ST_NORM;
               end
            end
            ST_NORM: begin
               // carry into the next field and settle it before coming back
               if (norm_ge) begin
                  unique case (fld_ff)
                     FLD_SEC: begin
                        sec_ff <= norm_diff;
                        min_ff <= norm_upper_inc;
                        fld_ff <= FLD_MIN;
                     end
                     FLD_MIN: begin
                        min_ff  <= norm_diff;
                        hour_ff <= norm_upper_inc;
                        fld_ff  <= FLD_HOUR;
                     end
                     default: begin
                        hour_ff <= norm_diff;
                        day_ff  <= norm_upper_inc;
                        if (norm_upper_inc == 8'd0) begin
                           if (flags_ff[FLAG_DAYHIGH]) begin
                              flags_ff <= (flags_ff & ~(8'd1 << FLAG_DAYHIGH))
                                          | (8'd1 << FLAG_OVERFLOW);
                           end else begin
                              flags_ff <= flags_ff | (8'd1 << FLAG_DAYHIGH);
                           end
                        end
                     end
                  endcase
               end else if (fld_ff == FLD_SEC) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_target_ff <= TGT_NONE;
                  rsp_maddr_ff  <= 21'd0;
                  rsp_rdata_ff  <= 8'd0;
                  rsp_wr_ff     <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else begin
                  fld_ff <= fld_ff - 2'd1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target          = rsp_target_ff;
   assign rsp_mapped_addr     = rsp_maddr_ff;
   assign rsp_clock_read_data = rsp_rdata_ff;
   assign rsp_is_write        = rsp_wr_ff;

   // at most one result per item
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two results in a row");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item taken but block not busy");

   a_maddr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_target_ff != TGT_ROM && rsp_target_ff != TGT_RAM)
         |-> (rsp_maddr_ff == 21'd0))
      else $error("mapped address set on a non-memory target");

   a_wr_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_wr_ff) |-> (rsp_target_ff != TGT_NONE && rsp_target_ff != TGT_ROM))
      else $error("write reported on unmapped or rom target");

   a_frozen_src: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && frozen_ff != $past(frozen_ff))
         |-> $past(state_ff == ST_EXEC && wr_latch))
      else $error("freeze flag changed without a latch write");

   a_norm_clk_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NORM) |-> (fld_ff != 2'd3))
      else $error("normalization field select out of range");

endmodule
